[design/u8dec_pkg.sv]
// Package for the UTF-8 stream decoder.
// Holds field widths, byte-class constants and the state/result structs.
// No dependencies.
package u8dec_pkg;

	localparam int unsigned ByteW  = 8;
	localparam int unsigned CpW    = 21;
	localparam int unsigned RemW   = 2;
	localparam int unsigned TdataW = ((CpW + 7) / 8) * 8;

	// Continuation byte tag in the top two bits
	localparam logic [1:0] ContTag = 2'b10;

	// Bytes still expected after each start byte class
	localparam logic [RemW-1:0] RemNone  = 2'd0;
	localparam logic [RemW-1:0] RemTwo   = 2'd1;
	localparam logic [RemW-1:0] RemThree = 2'd2;
	localparam logic [RemW-1:0] RemFour  = 2'd3;

	// Decoder state carried from byte to byte
	typedef struct packed {
		logic [RemW-1:0] bytes_remaining;
		logic [CpW-1:0]  accumulator;
	} dec_state_t;

	// One result item
	typedef struct packed {
		logic [CpW-1:0] code_point;
		logic           seq_error;
	} dec_result_t;

endpackage

[design/utf8_stream_decoder_unit.sv]
// UTF-8 stream decoder, top level: input register, decode step, result register.
// Depends on u8dec_pkg and u8dec_step.
// Throughput: one byte per cycle, set by the single decode step, unless
// a new result meets a full result register while m_tready is low.
// Bytes inside a sequence give no result and never wait on the master side.
// Reset (arst_n low, async): pipeline empty, no sequence open, pass-through on.
module utf8_stream_decoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave side
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [u8dec_pkg::ByteW-1:0]   s_tdata,   // [7:0] in_byte
	// master side
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [u8dec_pkg::TdataW-1:0]  m_tdata,   // [20:0] code_point, rest zero
	output logic                          m_tuser,   // [0] seq_error
	// configuration
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data // pass_through_enable
);
	import u8dec_pkg::*;

	logic               in_valid_s1;
	logic [ByteW-1:0]   in_byte_s1;
	dec_state_t         state_q;
	dec_state_t         state_next;
	logic               pass_through_q;
	logic               step_emit;
	dec_result_t        step_result;
	logic               out_valid_q;
	dec_result_t        out_result_q;
	logic               s1_advance;

	// Decode logic on the registered byte
	u8dec_step u_step (
		.in_byte             (in_byte_s1),
		.pass_through_enable (pass_through_q),
		.cur_state           (state_q),
		.next_state          (state_next),
		.emit                (step_emit),
		.result              (step_result)
	);

	// Stage 1 moves on unless it has a result and the result register is held
	assign s1_advance = in_valid_s1 && (!step_emit || !out_valid_q || m_tready);
	assign s_tready   = !in_valid_s1 || s1_advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
		end
	end

	// Sequence state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			pass_through_q <= 1'b1;
		end else begin
			if (s1_advance) begin
				state_q <= state_next;
			end
			if (cfg_wr_en) begin
				pass_through_q <= cfg_wr_data;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_advance && step_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance && step_emit) begin
			out_result_q <= step_result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TdataW-CpW){1'b0}}, out_result_q.code_point};
	assign m_tuser  = out_result_q.seq_error;

endmodule

[design/u8dec_step.sv]
// Per-byte decode step: next decoder state and optional result.
// Pure combinational logic; depends on u8dec_pkg.
module u8dec_step (
	input  logic [u8dec_pkg::ByteW-1:0] in_byte,
	input  logic                        pass_through_enable,
	input  u8dec_pkg::dec_state_t       cur_state,
	output u8dec_pkg::dec_state_t       next_state,
	output logic                        emit,
	output u8dec_pkg::dec_result_t      result
);
	import u8dec_pkg::*;

	logic [CpW-1:0] acc_shift;
	logic [CpW-1:0] byte_ext;

	assign acc_shift = {cur_state.accumulator[CpW-7:0], in_byte[5:0]};
	assign byte_ext  = {{(CpW-ByteW){1'b0}}, in_byte};

	// Decode one byte against the current sequence state
	always_comb begin
		next_state        = cur_state;
		emit              = 1'b0;
		result.code_point = '0;
		result.seq_error  = 1'b0;
		if (cur_state.bytes_remaining != RemNone) begin
			if (in_byte[7:6] != ContTag) begin
				// bad continuation: drop byte, end sequence
				next_state.bytes_remaining = RemNone;
				emit                       = 1'b1;
				result.seq_error           = 1'b1;
			end else begin
				next_state.bytes_remaining = cur_state.bytes_remaining - 2'd1;
				next_state.accumulator     = acc_shift;
				if (cur_state.bytes_remaining == RemTwo) begin
					emit              = 1'b1;
					result.code_point = acc_shift;
				end
			end
		end else begin
			if (in_byte inside {[8'h00:8'h7f]}) begin
				emit              = 1'b1;
				result.code_point = byte_ext;
			end else if (pass_through_enable && (in_byte inside {[8'h80:8'hbf]})) begin
				// stray continuation passed through as a value
				emit              = 1'b1;
				result.code_point = byte_ext;
			end else if (in_byte inside {[8'hf8:8'hff]}) begin
				emit             = 1'b1;
				result.seq_error = 1'b1;
			end else if (in_byte inside {[8'hf0:8'hf7]}) begin
				next_state.bytes_remaining = RemFour;
				next_state.accumulator     = {{(CpW-3){1'b0}}, in_byte[2:0]};
			end else if (in_byte inside {[8'he0:8'hef]}) begin
				next_state.bytes_remaining = RemThree;
				next_state.accumulator     = {{(CpW-4){1'b0}}, in_byte[3:0]};
			end else if (in_byte inside {[8'hc0:8'hdf]}) begin
				next_state.bytes_remaining = RemTwo;
				next_state.accumulator     = {{(CpW-5){1'b0}}, in_byte[4:0]};
			end else begin
				// stray continuation with pass-through off
				emit             = 1'b1;
				result.seq_error = 1'b1;
			end
		end
	end

endmodule

[sim/utf8_stream_decoder_unit_tb.sv]
// Testbench for utf8_stream_decoder_unit: directed byte table, then random UTF-8 traffic.
// Every accepted byte is run through a local decoder model; results are checked in order.
// Depends on u8dec_pkg and the decoder RTL.
`timescale 1ns / 100ps

module utf8_stream_decoder_unit_tb;
	import u8dec_pkg::*;

	localparam int unsigned BytesPerPhase = 160;
	localparam int unsigned NumPhases     = 4;
	localparam int unsigned DrainCycles   = 8;
	localparam int unsigned ShowLimit     = 10;

	// Byte classes
	localparam logic [7:0] AsciiTop  = 8'h7F;
	localparam logic [7:0] StrayTop  = 8'hBF;
	localparam logic [7:0] Lead2Base = 8'hC0;
	localparam logic [7:0] Lead3Base = 8'hE0;
	localparam logic [7:0] Lead4Base = 8'hF0;
	localparam logic [7:0] BadLead   = 8'hF8;
	localparam logic [7:0] ContBase  = 8'h80;

	typedef enum logic [1:0] {
		ROW_MODEL,	// expectation comes from the local decoder
		ROW_FIXED,	// expectation typed into the table
		ROW_CFG		// pass-through write, value in the byte column
	} row_kind_t;

	typedef struct packed {
		row_kind_t      kind;
		logic [7:0]     value;
		logic [CpW-1:0] cp;
		logic           err;
	} dir_row_t;

	localparam int unsigned NumRows = 26;
	localparam dir_row_t DirRows [0:NumRows-1] = '{
		'{ROW_FIXED, 8'h00, 21'h000000, 1'b0},	// first byte after reset
		'{ROW_FIXED, 8'h7F, 21'h00007F, 1'b0},	// top of ASCII
		'{ROW_FIXED, 8'h80, 21'h000080, 1'b0},	// stray byte, pass-through on
		'{ROW_FIXED, 8'hBF, 21'h0000BF, 1'b0},	// top of the stray range is passed too
		'{ROW_FIXED, 8'hF8, 21'h000000, 1'b1},	// invalid start byte
		'{ROW_FIXED, 8'hFF, 21'h000000, 1'b1},
		'{ROW_MODEL, 8'hC3, 21'h0, 1'b0},	// two-byte sequence
		'{ROW_MODEL, 8'hA9, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hE2, 21'h0, 1'b0},	// three-byte sequence
		'{ROW_MODEL, 8'h82, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hAC, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hF7, 21'h0, 1'b0},	// largest four-byte value
		'{ROW_MODEL, 8'hBF, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hBF, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hBF, 21'h0, 1'b0},
		'{ROW_MODEL, 8'hC3, 21'h0, 1'b0},	// bad continuation, dropped
		'{ROW_FIXED, 8'h41, 21'h000000, 1'b1},
		'{ROW_MODEL, 8'hF0, 21'h0, 1'b0},	// four-byte cut by a start byte
		'{ROW_MODEL, 8'h9F, 21'h0, 1'b0},
		'{ROW_FIXED, 8'hF5, 21'h000000, 1'b1},
		'{ROW_CFG,   8'h00, 21'h0, 1'b0},	// pass-through off
		'{ROW_FIXED, 8'h80, 21'h000000, 1'b1},	// stray bytes now errors
		'{ROW_FIXED, 8'hBF, 21'h000000, 1'b1},
		'{ROW_MODEL, 8'hC0, 21'h0, 1'b0},	// overlong zero is not checked
		'{ROW_MODEL, 8'h80, 21'h0, 1'b0},
		'{ROW_CFG,   8'h01, 21'h0, 1'b0}	// pass-through back on
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [ByteW-1:0]    s_tdata;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [TdataW-1:0]   m_tdata;
	logic                m_tuser;
	logic                cfg_wr_en;
	logic                cfg_wr_data;

	// Local decoder state
	logic [RemW-1:0]     rem_left;
	logic [CpW-1:0]      cp_acc;
	logic                pass_on;

	dec_result_t         pending_points[$];
	dec_result_t         want;
	int unsigned         bad_count = 0;
	int unsigned         shown = 0;
	int unsigned         burst_left = 0;
	int unsigned         bytes_sent = 0;

	// Receiver stall pattern, reloaded whenever stall_pos wraps
	logic [63:0]         ready_pat = '1;
	logic [5:0]          stall_pos = '0;

	utf8_stream_decoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Decode one byte; returns 1 when the byte completes a result
	function automatic logic decode_byte(input logic [7:0] b, output dec_result_t res);
		res = '0;
		if (rem_left != RemNone) begin
			if (b[7:6] != ContTag) begin
				rem_left = RemNone;
				res.seq_error = 1'b1;
				return 1'b1;
			end
			rem_left = rem_left - 1'b1;
			cp_acc = {cp_acc[CpW-7:0], b[5:0]};
			if (rem_left != RemNone)
				return 1'b0;
			res.code_point = cp_acc;
			return 1'b1;
		end
		if (b <= AsciiTop || (pass_on && b <= StrayTop)) begin
			res.code_point = CpW'(b);
			return 1'b1;
		end
		if (b >= BadLead) begin
			res.seq_error = 1'b1;
			return 1'b1;
		end
		if (b >= Lead4Base) begin
			rem_left = RemFour;
			cp_acc = CpW'(b[2:0]);
			return 1'b0;
		end
		if (b >= Lead3Base) begin
			rem_left = RemThree;
			cp_acc = CpW'(b[3:0]);
			return 1'b0;
		end
		if (b >= Lead2Base) begin
			rem_left = RemTwo;
			cp_acc = CpW'(b[4:0]);
			return 1'b0;
		end
		res.seq_error = 1'b1;
		return 1'b1;
	endfunction

	// Present one byte, in bursts with random gaps; returns at the edge of its transfer
	task automatic push_byte(input logic [7:0] b, input logic fixed, input dec_result_t fixed_res);
		int unsigned gap;
		dec_result_t res;
		logic        has_res;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
		has_res = decode_byte(b, res);
		if (fixed)
			pending_points = {pending_points, fixed_res};
		else if (has_res)
			pending_points = {pending_points, res};
	endtask

	// Hold the sender until every result is out, then write pass-through
	task automatic set_pass_through(input logic v);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_points.size() != 0) @(posedge clk);
		// bytes mid-sequence leave no result; let the pipeline empty
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		pass_on = v;
	endtask

	function automatic logic [7:0] lead_byte(input int unsigned len);
		case (len)
			2:       return Lead2Base | 8'($urandom_range(0, 31));
			3:       return Lead3Base | 8'($urandom_range(0, 15));
			default: return Lead4Base | 8'($urandom_range(0, 7));
		endcase
	endfunction

	// One random character: mostly well formed, some strays, bad leads and cut sequences
	task automatic send_char();
		int unsigned kind;
		int unsigned len;
		int unsigned i;
		logic [7:0]  b;
		kind = $urandom_range(0, 99);
		if (kind < 60) begin
			len = $urandom_range(1, 4);
			if (len == 1) begin
				push_byte(8'($urandom_range(0, 127)), 1'b0, '0);
			end else begin
				push_byte(lead_byte(len), 1'b0, '0);
				for (i = 1; i < len; i++)
					push_byte(ContBase | 8'($urandom_range(0, 63)), 1'b0, '0);
			end
		end else if (kind < 70) begin
			push_byte(8'($urandom_range(ContBase, StrayTop)), 1'b0, '0);
		end else if (kind < 77) begin
			push_byte(8'($urandom_range(BadLead, 8'hFF)), 1'b0, '0);
		end else if (kind < 90) begin
			// sequence broken by a byte that is not a continuation
			len = $urandom_range(2, 4);
			push_byte(lead_byte(len), 1'b0, '0);
			for (i = $urandom_range(0, len - 2); i > 0; i--)
				push_byte(ContBase | 8'($urandom_range(0, 63)), 1'b0, '0);
			b = $urandom_range(0, 1) ? 8'($urandom_range(0, 127))
			                         : 8'($urandom_range(Lead2Base, 8'hFF));
			push_byte(b, 1'b0, '0);
		end else begin
			push_byte(8'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	// Receiver stalls
	always @(posedge clk) begin
		if (stall_pos == 6'd63) begin
			case ($urandom_range(0, 3))
				0:       ready_pat <= '1;
				1:       ready_pat <= {$urandom, $urandom};
				default: ready_pat <= {$urandom, $urandom} | {$urandom, $urandom};
			endcase
		end
		stall_pos <= stall_pos + 1'b1;
		m_tready  <= ready_pat[stall_pos];
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				bad_count++;
				if (shown < ShowLimit) begin
					shown++;
					$display("unexpected transfer: cp=%h err=%b", m_tdata, m_tuser);
				end
			end else begin
				want = pending_points.pop_front();
				if (m_tdata != TdataW'(want.code_point) || m_tuser != want.seq_error) begin
					bad_count++;
					if (shown < ShowLimit) begin
						shown++;
						$display("mismatch: expected cp=%h err=%b, got cp=%h err=%b",
						         want.code_point, want.seq_error, m_tdata, m_tuser);
					end
				end
			end
		end
	end

	// Stimulus
	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = 1'b0;
		rem_left    = RemNone;
		cp_acc      = '0;
		pass_on     = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NumRows; r++) begin
			if (DirRows[r].kind == ROW_CFG)
				set_pass_through(DirRows[r].value[0]);
			else
				push_byte(DirRows[r].value, DirRows[r].kind == ROW_FIXED,
				          '{code_point: DirRows[r].cp, seq_error: DirRows[r].err});
		end

		for (int p = 0; p < NumPhases; p++) begin
			set_pass_through(p == 0 ? 1'b0 : p == 1 ? 1'b1 : 1'($urandom_range(0, 1)));
			while (bytes_sent < NumRows - 2 + (p + 1) * BytesPerPhase)
				send_char();
		end

		s_tvalid <= 1'b0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		bad_count += pending_points.size();
		if (bad_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

[files.f]
design/u8dec_pkg.sv
design/u8dec_step.sv
design/utf8_stream_decoder_unit.sv
sim/utf8_stream_decoder_unit_tb.sv
